[hdl/crc_pkg.sv]
// Package for the consecutive run condenser: payload structs, emission record and constants.
// Depends on nothing; used by consecutive_run_condenser_core.
`default_nettype none

package crc_pkg;

  // One input request: a stream byte and its end-of-stream flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_req_t;

  // One result request: an emitted byte and the flag on the last result of an item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_req_t;

  // Result bytes produced by one input item, slot 0 goes out first.
  localparam int unsigned MaxResults = 6;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [2:0]                 count;
  } emit_t;

  localparam logic [7:0] DotChar = 8'd46;
  localparam logic [1:0] LenSat  = 2'd3;
  localparam logic [1:0] MinRun  = 2'd3;
  localparam logic       StepReset = 1'b1;

endpackage

`default_nettype wire

[hdl/consecutive_run_condenser_core.sv]
// Consecutive run condenser: top level with run tracking and a six-byte result buffer.
// Depends on crc_pkg for the payload structs, emission record and constants.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   crc_pkg::in_req_t  (data_byte, end_of_stream)
// out       output     out_valid_o / out_ready_i crc_pkg::out_req_t (out_byte, out_last)
// cfg       input      cfg_we_i (no wait)        cfg_wdata_i        (run_step)
//
// A request is processed in the cycle it is accepted: the run registers update and every result
// byte it causes is loaded into the result buffer at once. The buffer then drains one byte per
// cycle while the output is ready. An item causes up to six result bytes, and one that causes
// none leaves the input open; otherwise the next request is taken in the cycle the final buffered
// byte leaves. Reset puts the run step at 1, clears the pending run and empties the buffer.
// A stall on the output side holds the buffer and, once it is down to its last byte, the input.

module consecutive_run_condenser_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire crc_pkg::in_req_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output crc_pkg::out_req_t      out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i
);

  // Run state: first and latest byte of the pending run and its saturating length,
  // where a length of zero means no run is pending.
  logic       step_q;
  logic [7:0] first_q, first_d;
  logic [7:0] prev_q, prev_d;
  logic [1:0] len_q, len_d;

  // Result buffer: slot 0 is the byte on the output, the rest shift down as bytes are taken.
  logic [crc_pkg::MaxResults-1:0][7:0] buf_q, buf_d;
  logic [2:0]                          cnt_q, cnt_d;

  logic           in_acc;
  logic           out_acc;
  logic           extend;
  logic [8:0]     next_expected;
  logic [1:0]     len_ext;
  crc_pkg::emit_t emit;

  // Builds the printed form of a run: condensed with three dots when long enough,
  // otherwise its bytes one by one, and nothing for an empty run.
  function automatic crc_pkg::emit_t emit_run(logic [7:0] first, logic [7:0] last,
                                              logic [1:0] len);
    crc_pkg::emit_t r;
    r.bytes = '0;
    r.count = 3'd0;
    if (len >= crc_pkg::MinRun) begin
      r.bytes[0] = first;
      r.bytes[1] = crc_pkg::DotChar;
      r.bytes[2] = crc_pkg::DotChar;
      r.bytes[3] = crc_pkg::DotChar;
      r.bytes[4] = last;
      r.count    = 3'd5;
    end else if (len == 2'd2) begin
      r.bytes[0] = first;
      r.bytes[1] = last;
      r.count    = 3'd2;
    end else if (len == 2'd1) begin
      r.bytes[0] = first;
      r.count    = 3'd1;
    end
    return r;
  endfunction

  assign out_acc     = out_valid_o && out_ready_i;
  // The input may load the buffer once it is empty or its last byte leaves in this cycle.
  assign in_ready_o  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  assign out_valid_o         = (cnt_q != 3'd0);
  assign out_data_o.out_byte = buf_q[0];
  assign out_data_o.out_last = (cnt_q == 3'd1);

  // The run extends only on an exact step, without wrapping past 255.
  assign next_expected = {1'b0, prev_q} + {8'd0, step_q};
  assign extend        = (len_q != 2'd0) && (next_expected == {1'b0, in_data_i.data_byte});
  assign len_ext       = (len_q == crc_pkg::LenSat) ? len_q : len_q + 2'd1;

  always_comb begin
    first_d = first_q;
    prev_d  = prev_q;
    len_d   = len_q;
    emit    = '0;
    if (extend) begin
      prev_d = in_data_i.data_byte;
      len_d  = len_ext;
      if (in_data_i.end_of_stream) begin
        emit  = emit_run(first_q, in_data_i.data_byte, len_ext);
        len_d = 2'd0;
      end
    end else begin
      // The broken run goes out first, then the new one-byte run if the stream ends here.
      emit    = emit_run(first_q, prev_q, len_q);
      first_d = in_data_i.data_byte;
      prev_d  = in_data_i.data_byte;
      len_d   = 2'd1;
      if (in_data_i.end_of_stream) begin
        emit.bytes[emit.count] = in_data_i.data_byte;
        emit.count             = emit.count + 3'd1;
        len_d                  = 2'd0;
      end
    end
  end

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      // Loading happens only when the buffer is empty or emptying, so it replaces the contents.
      buf_d = emit.bytes;
      cnt_d = emit.count;
    end else if (out_acc) begin
      buf_d = buf_q >> 8;
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= crc_pkg::StepReset;
      first_q <= 8'd0;
      prev_q  <= 8'd0;
      len_q   <= 2'd0;
      cnt_q   <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        first_q <= first_d;
        prev_q  <= prev_d;
        len_q   <= len_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // The buffer never holds more than one item's worth of results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd6)
    else $error("result buffer count out of range");

  // The end of the stream always flushes something and leaves no run pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.end_of_stream) |=> (out_valid_o && (len_q == 2'd0)))
    else $error("end of stream did not flush the pending run");

  // Any other byte leaves a run pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_data_i.end_of_stream) |=> (len_q != 2'd0))
    else $error("byte without end of stream left no pending run");

  // A byte that only extends a run, without ending the stream, causes no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && extend && !in_data_i.end_of_stream) |=> !out_valid_o)
    else $error("extending byte produced a result");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for consecutive_run_condenser_core: predicts every condensed or
// byte-for-byte result from its own run tracker and compares each result request in order.
// Depends on crc_pkg for the request structs and on the core itself.

module tb_top;

  // Step values of the single configuration register.
  localparam logic StepRepeat    = 1'b0;
  localparam logic StepAscending = 1'b1;

  // Runs of at least this length leave as first byte, three dots and last byte.
  localparam logic [1:0] CondenseLen = 2'd3;
  localparam logic [1:0] RunLenMax   = 2'd3;
  localparam logic [7:0] DotByte     = 8'd46;

  // Settling wait after the last expected result, so that the core finishes the current item.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  crc_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  crc_pkg::out_req_t out_req;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;

  consecutive_run_condenser_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_req),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Our own copy of the run tracker: the pending run, its length and the configured step.
  logic [7:0] run_head;
  logic [7:0] run_tail;
  logic [1:0] run_len;
  logic       step_sel;

  // Result requests we expect from the core, oldest first.
  crc_pkg::out_req_t pending_bytes[$];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_on = 1'b0;
  int unsigned stall_left = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic void queue_byte(input logic [7:0] b);
    crc_pkg::out_req_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    pending_bytes.push_back(r);
  endfunction

  // Emits the pending run, if any: condensed when long enough, otherwise byte for byte.
  function automatic void flush_run();
    if (run_len == 2'd0) return;
    if (run_len >= CondenseLen) begin
      queue_byte(run_head);
      queue_byte(DotByte);
      queue_byte(DotByte);
      queue_byte(DotByte);
      queue_byte(run_tail);
    end else if (run_len == 2'd2) begin
      queue_byte(run_head);
      queue_byte(run_tail);
    end else begin
      queue_byte(run_head);
    end
    run_len = 2'd0;
  endfunction

  // Updates the run tracker for one accepted input request and queues what it causes.
  // The sum is taken one bit wider so that 255 followed by 0 never extends an ascending run.
  function automatic void predict_condense(input crc_pkg::in_req_t req);
    int unsigned       n_before;
    crc_pkg::out_req_t tail_req;
    n_before = pending_bytes.size();
    if (run_len != 2'd0 && ({1'b0, run_tail} + {8'd0, step_sel}) == {1'b0, req.data_byte}) begin
      run_tail = req.data_byte;
      if (run_len < RunLenMax) run_len = run_len + 2'd1;
    end else begin
      flush_run();
      run_head = req.data_byte;
      run_tail = req.data_byte;
      run_len  = 2'd1;
    end
    if (req.end_of_stream) flush_run();
    // The final result caused by this request carries the last flag.
    if (pending_bytes.size() > n_before) begin
      tail_req = pending_bytes.pop_back();
      tail_req.out_last = 1'b1;
      pending_bytes.push_back(tail_req);
    end
  endfunction

  // Sends one request. It is called at a rising edge and returns at the edge where the
  // request was accepted, with valid still high, so that the next request can follow
  // without a bubble. A random gap, when taken, lowers valid first.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req.data_byte     <= b;
    in_req.end_of_stream <= eos;
    do @(posedge clk_i); while (!in_ready);
    predict_condense(in_req);
  endtask

  // Holds the input off until every expected result has left the core, then lets the
  // core finish any item that produced no result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes happen only with the core idle.
  task automatic set_run_step(input logic stp);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= stp;
    @(posedge clk_i);
    step_sel = stp;
    cfg_we <= 1'b0;
  endtask

  // Ascending runs at reset step: condensed, short and broken runs, no wrap at 255,
  // a break and the end of stream on the same request, and a lone final byte.
  task automatic test_ascending_runs();
    send_byte(8'h61, 1'b0);  // 'a' 'b' 'c' 'd' then end: condensed
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(8'h64, 1'b1);
    send_byte(8'd10, 1'b0);  // two-byte run broken, then the breaker flushed alone
    send_byte(8'd11, 1'b0);
    send_byte(8'd20, 1'b1);
    send_byte(8'd254, 1'b0); // 254, 255 must not carry over into 0
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd1, 1'b1);
    send_byte(8'h41, 1'b0);  // condensed run broken by an end-of-stream byte: six results
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'd200, 1'b1);
    send_byte(8'd255, 1'b1); // lone byte at the end of a stream
    send_byte(8'd5, 1'b0);   // a repeat does not extend an ascending run
    send_byte(8'd5, 1'b1);
  endtask

  // Repeated-byte runs with step 0, including a saturated long run.
  task automatic test_repeat_runs();
    set_run_step(StepRepeat);
    repeat (5) send_byte(8'd120, 1'b0);
    send_byte(8'd120, 1'b1);
    send_byte(8'd0, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd1, 1'b1);
    send_byte(8'd255, 1'b0);
    send_byte(8'd255, 1'b1);
  endtask

  // Random streams made mostly of runs that follow the current step, with some runs
  // using the other step, stray bytes and lone end-of-stream bytes mixed in.
  task automatic send_random_stream(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  start;
    logic        stp;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len   = $urandom_range(1, 6);
        start = 8'($urandom_range(0, 255));
        stp   = ($urandom_range(0, 4) == 0) ? ~step_sel : step_sel;
        for (int unsigned k = 0; k < len; k++) begin
          send_byte(start + 8'(k * stp), (k == len - 1) && ($urandom_range(0, 3) == 0));
        end
        sent += len;
      end else if (kind <= 8) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        sent++;
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end
    end
  endtask

  // Random phases with idling on both sides, switching the step between phases.
  task automatic test_random_runs();
    idle_on = 1'b1;
    set_run_step(StepAscending);
    send_random_stream(30);
    set_run_step(StepRepeat);
    send_random_stream(25);
    // The sender holds back here until all results are out, with no register write.
    wait_drained();
    send_random_stream(15);
    set_run_step(StepAscending);
    send_random_stream(25);
    set_run_step(StepRepeat);
    send_random_stream(10);
  endtask

  // Closing part with no idling anywhere: requests and results stream back to back.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    set_run_step(StepAscending);
    send_random_stream(15);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // The receiver stalls in random bursts while idling is on and is always ready otherwise.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result request is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    crc_pkg::out_req_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %0d last %0b",
                                  out_req.out_byte, out_req.out_last));
      end else begin
        want = pending_bytes.pop_front();
        if (out_req.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %0d, expected %0d",
                                    out_req.out_byte, want.out_byte));
        if (out_req.out_last !== want.out_last)
          report_mismatch($sformatf("out_last %0b, expected %0b on byte %0d",
                                    out_req.out_last, want.out_last, want.out_byte));
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    run_head = '0;
    run_tail = '0;
    run_len  = 2'd0;
    step_sel = StepAscending;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascending_runs();
    test_repeat_runs();
    test_random_runs();
    test_back_to_back();

    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
